[hdl/vtc_pkg.sv]
// ----------------------------------------------------------------------------
// vtc_pkg - shared constants and types for the vertex transform block
// Fixed-point format, stream widths, request kinds and the command/status
// structs that join the controller and the datapath.
// ----------------------------------------------------------------------------
package vtc_pkg;

    // fixed-point format of matrix words and clip-space results
    localparam int FRAC_BITS = 16;
    localparam longint ONE_FX = 64'sd1 << FRAC_BITS;
    localparam longint W_MIN  = (ONE_FX + 999) / 1000;  // 0.001 rounded up
    localparam longint W_NEAR = (ONE_FX + 9) / 10;      // 0.1 rounded up

    localparam int ACC_W     = 49;                 // clip-space word
    localparam int Q_W       = 31;                 // unsigned quotient bits
    localparam int DIV_STEPS = Q_W;
    localparam int ITER_W    = $clog2(DIV_STEPS);
    localparam int NUM_W     = ACC_W + FRAC_BITS;  // scaled dividend
    localparam int SAT_SH    = Q_W - FRAC_BITS;

    // stream widths
    localparam int IN_USER_W  = 2;
    localparam int IN_DATA_W  = 152;
    localparam int OUT_DATA_W = 400;

    // request kinds carried in tuser
    localparam logic [1:0] MODE_LD_INT  = 2'd0;
    localparam logic [1:0] MODE_LD_FRAC = 2'd1;
    localparam logic [1:0] MODE_VERTEX  = 2'd2;

    // controller to datapath
    typedef struct packed {
        logic       capture;
        logic       load_wr;
        logic       mul_en;
        logic [1:0] mul_row;
        logic [1:0] mul_col;
        logic       clamp;
        logic       div_init;
        logic       div_step;
        logic       div_store;
        logic [1:0] div_sel;
        logic       out_load;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic out_free;
    } t_stat;

endpackage

[hdl/vertex_transform_clip.sv]
// ----------------------------------------------------------------------------
// vertex_transform_clip - homogeneous vertex transform with clip codes
// Load requests pass through a single load state. A vertex passes through
// the shared multiplier over 16 matrix elements, accumulate and w clamp,
// then 4 quotients in the one-bit-per-cycle divider, which takes the largest
// share of each vertex; no new request enters until the vertex result has
// gone to the output register. A finished result waits in the output register
// while new requests enter; the next vertex stalls only while it is full.
// Synchronous active-low reset clears the matrix to zero and empties the
// output; no clearing pass is needed.
// ----------------------------------------------------------------------------
module vertex_transform_clip (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_s_tvalid,
    output logic                             o_s_tready,
    // tdata: elem_pair, load_data, pos_x, pos_y, pos_z, tex_s_in, tex_t_in,
    //        color_in, zero pad
    input  logic [vtc_pkg::IN_DATA_W-1:0]    i_s_tdata,
    // tuser: mode
    input  logic [vtc_pkg::IN_USER_W-1:0]    i_s_tuser,
    output logic                             o_m_tvalid,
    input  logic                             i_m_tready,
    // tdata: clip_x, clip_y, clip_z, clip_w, inv_w, ndc_x, ndc_y, ndc_z,
    //        clip_code, tex_s_out, tex_t_out, color_out, zero pad
    output logic [vtc_pkg::OUT_DATA_W-1:0]   o_m_tdata
);

    vtc_pkg::t_cmd  cmd;
    vtc_pkg::t_stat stat;

    // sequencer
    vtc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_tvalid),
        .i_in_mode  (i_s_tuser),
        .o_in_ready (o_s_tready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    // arithmetic and storage
    vtc_datapath u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .i_tdata    (i_s_tdata),
        .i_tuser    (i_s_tuser),
        .i_m_tready (i_m_tready),
        .o_m_tvalid (o_m_tvalid),
        .o_m_tdata  (o_m_tdata),
        .o_stat     (stat)
    );

endmodule

[hdl/vtc_ctrl.sv]
// ----------------------------------------------------------------------------
// vtc_ctrl - sequencer for the vertex transform block
// Accepts requests, steps the shared multiplier over the matrix, then runs
// the restoring divider once per quotient and hands the result off.
// ----------------------------------------------------------------------------
module vtc_ctrl (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    input  logic [vtc_pkg::IN_USER_W-1:0]   i_in_mode,
    output logic                            o_in_ready,
    input  vtc_pkg::t_stat                  i_stat,
    output vtc_pkg::t_cmd                   o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE, S_LOAD, S_MUL, S_ACC, S_CLAMP, S_DINIT, S_DRUN, S_DSTORE, S_OUT
    } t_state;

    t_state                      r_state, n_state;
    logic [3:0]                  r_step, n_step;
    logic [1:0]                  r_dsel, n_dsel;
    logic [vtc_pkg::ITER_W-1:0]  r_iter, n_iter;
    logic                        accept;

    assign o_in_ready = (r_state == S_IDLE);
    assign accept     = i_in_valid && o_in_ready;

    // next state and command decode
    always_comb begin
        n_state = r_state;
        n_step  = r_step;
        n_dsel  = r_dsel;
        n_iter  = r_iter;
        o_cmd   = '0;
        o_cmd.capture = accept;
        o_cmd.mul_row = r_step[1:0];
        o_cmd.mul_col = r_step[3:2];
        o_cmd.div_sel = r_dsel;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_step = '0;
                    if (i_in_mode == vtc_pkg::MODE_LD_INT ||
                        i_in_mode == vtc_pkg::MODE_LD_FRAC) begin
                        n_state = S_LOAD;
                    end else if (i_in_mode == vtc_pkg::MODE_VERTEX) begin
                        n_state = S_MUL;
                    end
                end
            end
            S_LOAD: begin
                o_cmd.load_wr = 1'b1;
                n_state = S_IDLE;
            end
            S_MUL: begin
                o_cmd.mul_en = 1'b1;
                n_step = r_step + 4'd1;
                if (r_step == 4'd15) n_state = S_ACC;
            end
            // last product lands in its accumulator
            S_ACC: n_state = S_CLAMP;
            S_CLAMP: begin
                o_cmd.clamp = 1'b1;
                n_dsel = '0;
                n_state = S_DINIT;
            end
            S_DINIT: begin
                o_cmd.div_init = 1'b1;
                n_iter = '0;
                n_state = S_DRUN;
            end
            S_DRUN: begin
                o_cmd.div_step = 1'b1;
                n_iter = r_iter + 1'b1;
                if (r_iter == vtc_pkg::ITER_W'(vtc_pkg::DIV_STEPS - 1)) n_state = S_DSTORE;
            end
            S_DSTORE: begin
                o_cmd.div_store = 1'b1;
                if (r_dsel == 2'd3) begin
                    n_state = S_OUT;
                end else begin
                    n_dsel = r_dsel + 2'd1;
                    n_state = S_DINIT;
                end
            end
            S_OUT: begin
                if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // state and counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_step  <= '0;
            r_dsel  <= '0;
            r_iter  <= '0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
            r_dsel  <= n_dsel;
            r_iter  <= n_iter;
        end
    end

endmodule

[hdl/vtc_datapath.sv]
// ----------------------------------------------------------------------------
// vtc_datapath - matrix store, shared multiplier and divider, result register
// One 16x32 multiply per cycle feeds four column accumulators; one
// restoring divider computes 1/w and the three perspective quotients.
// ----------------------------------------------------------------------------
module vtc_datapath (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  vtc_pkg::t_cmd                    i_cmd,
    input  logic [vtc_pkg::IN_DATA_W-1:0]    i_tdata,
    input  logic [vtc_pkg::IN_USER_W-1:0]    i_tuser,
    input  logic                             i_m_tready,
    output logic                             o_m_tvalid,
    output logic [vtc_pkg::OUT_DATA_W-1:0]   o_m_tdata,
    output vtc_pkg::t_stat                   o_stat
);

    localparam int F  = vtc_pkg::FRAC_BITS;
    localparam int AW = vtc_pkg::ACC_W;
    localparam int QW = vtc_pkg::Q_W;
    localparam int NW = vtc_pkg::NUM_W;
    localparam int PAD_W = vtc_pkg::OUT_DATA_W - (4 * AW + 4 * 32 + 5 + 16 + 16 + 32);
    localparam logic [31:0] FRAC_MASK = 32'((64'sd1 <<< F) - 1);

    // captured request
    logic [1:0]         r_mode;
    logic [2:0]         r_pair;
    logic [31:0]        r_data;
    logic signed [15:0] r_px, r_py, r_pz, r_tex_s, r_tex_t;
    logic [31:0]        r_color;

    // matrix as row-major element pairs, first element in the upper word
    logic [63:0] r_mat [8];

    logic signed [47:0]   r_prod;
    logic                 r_prod_vld, r_prod_first;
    logic [1:0]           r_prod_col;
    logic signed [AW-1:0] r_acc [4];

    logic [AW-1:0]   r_den;
    logic            r_wneg;
    logic [4:0]      r_code;
    logic [AW-1:0]   r_rem;
    logic [QW-1:0]   r_nsh, r_q;
    logic            r_sat, r_neg;
    logic [31:0]     r_res [4];
    logic            r_out_valid;
    logic [vtc_pkg::OUT_DATA_W-1:0] r_out_data;

    // integer half load: half scaled to the fixed grid
    function automatic logic [31:0] ld_int(input logic [15:0] half);
        logic signed [31:0] v;
        v = 32'(signed'(half));
        return 32'(v <<< F);
    endfunction

    // fraction load: keep integer part (toward zero), replace the fraction
    function automatic logic [31:0] ld_frac(input logic [31:0] old, input logic [15:0] half);
        logic [31:0] t;
        t = old & ~FRAC_MASK;
        if (old[31] && ((old & FRAC_MASK) != 32'd0)) t = t + 32'(64'sd1 <<< F);
        return t + 32'(half >> (16 - F));
    endfunction

    // matrix read: one pair address at a time
    logic [2:0]         rd_pair;
    logic [63:0]        rd_data;
    logic signed [31:0] elem;
    logic signed [15:0] pos_sel;
    logic signed [47:0] prod_n;

    assign rd_pair = i_cmd.load_wr ? r_pair : {i_cmd.mul_row, i_cmd.mul_col[1]};
    assign rd_data = r_mat[rd_pair];
    assign elem    = i_cmd.mul_col[0] ? rd_data[31:0] : rd_data[63:32];

    always_comb begin
        case (i_cmd.mul_row)
            2'd0:    pos_sel = r_px;
            2'd1:    pos_sel = r_py;
            2'd2:    pos_sel = r_pz;
            default: pos_sel = 16'sd1;  // translation row
        endcase
    end
    assign prod_n = pos_sel * elem;

    // clamp of w and clip codes
    logic signed [AW-1:0] w_raw, wc;
    logic [AW-1:0]        wmag;
    logic signed [AW:0]   wc50, nwc50, cx50, cy50;
    logic [4:0]           code_n;

    assign w_raw = r_acc[3];
    assign wmag  = w_raw[AW-1] ? AW'(-w_raw) : AW'(w_raw);
    assign wc    = (wmag < AW'(vtc_pkg::W_MIN)) ? AW'(vtc_pkg::W_MIN) : w_raw;
    assign wc50  = (AW+1)'(wc);
    assign nwc50 = -wc50;
    assign cx50  = (AW+1)'(r_acc[0]);
    assign cy50  = (AW+1)'(r_acc[1]);
    assign code_n = {wc < AW'(vtc_pkg::W_NEAR), cy50 > wc50, cy50 < nwc50,
                     cx50 > wc50, cx50 < nwc50};

    // divider setup
    logic signed [AW-1:0] num;
    logic [AW-1:0]        nmag;
    logic [NW-1:0]        nfull;
    logic [AW:0]          trial;
    logic                 ge;
    logic [31:0]          res_n;

    always_comb begin
        case (i_cmd.div_sel)
            2'd0:    num = AW'(vtc_pkg::ONE_FX);
            2'd1:    num = r_acc[0];
            2'd2:    num = r_acc[1];
            default: num = r_acc[2];
        endcase
    end
    assign nmag  = num[AW-1] ? AW'(-num) : AW'(num);
    assign nfull = NW'(nmag) << F;
    assign trial = {r_rem, r_nsh[QW-1]};
    assign ge    = trial >= {1'b0, r_den};
    assign res_n = r_sat ? (r_neg ? 32'h8000_0000 : 32'h7FFF_FFFF)
                         : (r_neg ? -{1'b0, r_q} : {1'b0, r_q});

    // control registers: matrix, product valid, result valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 8; i++) r_mat[i] <= '0;
            r_prod_vld  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.load_wr) begin
                if (r_mode == vtc_pkg::MODE_LD_INT) begin
                    r_mat[r_pair] <= {ld_int(r_data[31:16]), ld_int(r_data[15:0])};
                end else begin
                    r_mat[r_pair] <= {ld_frac(rd_data[63:32], r_data[31:16]),
                                      ld_frac(rd_data[31:0], r_data[15:0])};
                end
            end
            r_prod_vld <= i_cmd.mul_en;
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        // request capture
        if (i_cmd.capture) begin
            r_mode  <= i_tuser;
            r_pair  <= i_tdata[2:0];
            r_data  <= i_tdata[34:3];
            r_px    <= i_tdata[50:35];
            r_py    <= i_tdata[66:51];
            r_pz    <= i_tdata[82:67];
            r_tex_s <= i_tdata[98:83];
            r_tex_t <= i_tdata[114:99];
            r_color <= i_tdata[146:115];
        end
        // multiply then accumulate
        r_prod       <= prod_n;
        r_prod_col   <= i_cmd.mul_col;
        r_prod_first <= (i_cmd.mul_row == 2'd0);
        if (r_prod_vld) begin
            r_acc[r_prod_col] <= (r_prod_first ? '0 : r_acc[r_prod_col]) + AW'(r_prod);
        end
        // w clamp
        if (i_cmd.clamp) begin
            r_acc[3] <= wc;
            r_den    <= wc[AW-1] ? AW'(-wc) : AW'(wc);
            r_wneg   <= wc[AW-1];
            r_code   <= code_n;
        end
        // restoring divider
        if (i_cmd.div_init) begin
            r_rem <= AW'(nfull >> QW);
            r_nsh <= nfull[QW-1:0];
            r_q   <= '0;
            r_sat <= 64'(nmag) >= (64'(r_den) << vtc_pkg::SAT_SH);
            r_neg <= num[AW-1] ^ r_wneg;
        end else if (i_cmd.div_step) begin
            r_rem <= ge ? AW'(trial - {1'b0, r_den}) : trial[AW-1:0];
            r_nsh <= {r_nsh[QW-2:0], 1'b0};
            r_q   <= {r_q[QW-2:0], ge};
        end
        if (i_cmd.div_store) r_res[i_cmd.div_sel] <= res_n;
        // result register
        if (i_cmd.out_load) begin
            r_out_data <= {PAD_W'(0), r_color, r_tex_t, r_tex_s, r_code,
                           r_res[3], r_res[2], r_res[1], r_res[0],
                           r_acc[3], r_acc[2], r_acc[1], r_acc[0]};
        end
    end

    assign o_m_tvalid      = r_out_valid;
    assign o_m_tdata       = r_out_data;
    assign o_stat.out_free = !r_out_valid || i_m_tready;

endmodule
